FILE: hw/rtl/lu8_pkg.sv
// Shared types and constants for the lenient UTF-8 / Latin-1 byte decoder.
package lu8_pkg;

    // Encoding mode codes
    localparam logic MODE_UTF8   = 1'b0;
    localparam logic MODE_LATIN1 = 1'b1;

    // Lead byte class limits
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;

    // Payload masks for lead and continuation bytes
    localparam logic [7:0] CONT_MASK  = 8'h3F;
    localparam logic [7:0] LEAD2_MASK = 8'h1F;
    localparam logic [7:0] LEAD3_MASK = 8'h0F;
    localparam logic [7:0] LEAD4_MASK = 8'h07;

    localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;

    // One decoded result
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_count;
        logic        end_of_text;
    } lu8_result_t;

    // Sequence state carried between bytes
    typedef struct packed {
        logic [1:0]  bytes_pending;
        logic [20:0] partial_value;
        logic [2:0]  sequence_length;
    } lu8_state_t;

endpackage

FILE: hw/rtl/lu8_decode.sv
// Combinational per-byte decode step: next sequence state and optional result.
module lu8_decode (
    input  logic                 encoding_mode,
    input  logic [7:0]           byte_in,
    input  lu8_pkg::lu8_state_t  state,
    output lu8_pkg::lu8_state_t  state_next,
    output logic                 res_valid,
    output lu8_pkg::lu8_result_t res
);
    import lu8_pkg::*;

    logic [20:0] cont_value;

    // Shift in the low six bits of a continuation byte
    assign cont_value = {state.partial_value[14:0], byte_in[5:0] & CONT_MASK[5:0]};

    always_comb
    begin
        state_next      = state;
        res_valid       = 1'b0;
        res.code_point  = 21'd0;
        res.byte_count  = 3'd0;
        res.end_of_text = 1'b0;

        if (state.bytes_pending != 2'd0)
        begin
            // Continuation byte; its value is not checked.
            state_next.partial_value = cont_value;
            state_next.bytes_pending = state.bytes_pending - 2'd1;
            if (state.bytes_pending == 2'd1)
            begin
                res_valid      = 1'b1;
                res.code_point = cont_value;
                res.byte_count = state.sequence_length;
            end
        end
        else if (byte_in == 8'd0)
        begin
            // Zero byte at a character start marks the end of text.
            res_valid       = 1'b1;
            res.end_of_text = 1'b1;
        end
        else if (encoding_mode == MODE_LATIN1 || byte_in <= ASCII_MAX)
        begin
            res_valid      = 1'b1;
            res.code_point = {13'd0, byte_in};
            res.byte_count = 3'd1;
        end
        else if (byte_in <= LEAD2_MAX)
        begin
            state_next.partial_value   = {13'd0, byte_in & LEAD2_MASK};
            state_next.sequence_length = 3'd2;
            state_next.bytes_pending   = 2'd1;
        end
        else if (byte_in <= LEAD3_MAX)
        begin
            state_next.partial_value   = {13'd0, byte_in & LEAD3_MASK};
            state_next.sequence_length = 3'd3;
            state_next.bytes_pending   = 2'd2;
        end
        else if (byte_in <= LEAD4_MAX)
        begin
            state_next.partial_value   = {13'd0, byte_in & LEAD4_MASK};
            state_next.sequence_length = 3'd4;
            state_next.bytes_pending   = 2'd3;
        end
        else
        begin
            // Lead byte that can never start a valid sequence.
            res_valid      = 1'b1;
            res.code_point = REPLACEMENT_CHAR;
            res.byte_count = 3'd1;
        end
    end

endmodule

FILE: hw/rtl/lu8_out_buffer.sv
// Result register with a skid stage so the input side waits on out_ready only when the skid stage is full.
module lu8_out_buffer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lu8_pkg::lu8_result_t push_data,
    output logic                 can_push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lu8_pkg::lu8_result_t out_data
);
    import lu8_pkg::*;

    logic        main_valid_reg;
    logic        skid_valid_reg;
    lu8_result_t main_reg;
    lu8_result_t skid_reg;
    logic        pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            main_valid_reg <= push || skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

endmodule

FILE: hw/rtl/lenient_utf8_byte_decoder.sv
// A result is registered in the result register, or behind it in the skid stage, on the transaction of its last byte.
// Throughput: one byte per cycle; the input is held off only when both the result
// register and its skid stage are full.
// Reset: rst_n clears the sequence state, the output valid flags and selects UTF-8
// mode; result payload registers are not reset.
module lenient_utf8_byte_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] code_point,
    output logic [2:0]  byte_count,
    output logic        end_of_text
);
    import lu8_pkg::*;

    logic        encoding_mode_reg;
    lu8_state_t  state_reg;
    lu8_state_t  state_next;
    logic        res_valid;
    lu8_result_t res;
    lu8_result_t out_data;
    logic        in_accept;

    assign in_accept = in_valid && in_ready;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoding_mode_reg <= MODE_UTF8;
        end
        else if (cfg_write_en)
        begin
            encoding_mode_reg <= cfg_write_data;
        end
    end

    // Sequence state advances on every input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    lu8_decode u_decode (
        .encoding_mode (encoding_mode_reg),
        .byte_in       (byte_in),
        .state         (state_reg),
        .state_next    (state_next),
        .res_valid     (res_valid),
        .res           (res)
    );

    lu8_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept && res_valid),
        .push_data (res),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign code_point  = out_data.code_point;
    assign byte_count  = out_data.byte_count;
    assign end_of_text = out_data.end_of_text;

    // An end-of-text result carries no character.
    a_eot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_text |-> code_point == 21'd0 && byte_count == 3'd0)
        else $error("end-of-text result with nonzero payload");

    // The skid stage only fills behind a held result.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("skid stage full while result register empty");

    // Pending count never reaches the sequence length.
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bytes_pending != 2'd0 |->
            state_reg.sequence_length > {1'b0, state_reg.bytes_pending})
        else $error("pending count inconsistent with sequence length");

    // A completed character never reports more than four bytes.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_count <= 3'd4)
        else $error("byte count out of range");

endmodule
